// File: src/lccf_pkg.sv
// ----------------------------------------------------------------------------
// lccf_pkg
// Shared widths, codes and types of the linear cluster correlation filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lccf_pkg;

    // hit and cluster limits
    localparam int MAX_HITS   = 4096;
    localparam int TIER_COUNT = 3;

    // field and accumulator widths
    localparam int W_HIT  = 13;   // wire and time of one hit
    localparam int W_CNT  = 13;   // hit count, holds MAX_HITS
    localparam int W_S1   = 25;   // sum of wires or times
    localparam int W_S2   = 38;   // sum of squares or cross products
    localparam int W_V    = 50;   // n*S2 and S1*S1 terms, variances, |covariance|
    localparam int W_SQ   = 100;  // covariance squared, variance product
    localparam int W_LIM  = 17;   // limit, unsigned Q1.16
    localparam int W_L2   = 34;   // limit squared
    localparam int W_P    = 134;  // widest product: limit^2 * variance product
    localparam int W_NB   = 6;    // multiplier bit counter
    localparam int W_ADDR = 3;    // register index
    localparam int W_TIER = 2;    // tiers in use

    // register indexes of the write port
    typedef enum logic [W_ADDR-1:0] {
        REG_LIMIT_TIER0    = 3'd0,
        REG_LIMIT_TIER1    = 3'd1,
        REG_LIMIT_TIER2    = 3'd2,
        REG_MIN_HITS_TIER0 = 3'd3,
        REG_MIN_HITS_TIER1 = 3'd4,
        REG_MIN_HITS_TIER2 = 3'd5,
        REG_TIERS_IN_USE   = 3'd6
    } reg_idx_t;

    // multiply steps of the end-of-cluster sequence, in order
    typedef enum logic [3:0] {
        OP_N_SWW  = 4'd0,   // n * sum w^2
        OP_SW_SW  = 4'd1,   // sum w * sum w, gives wire variance
        OP_N_STT  = 4'd2,   // n * sum t^2
        OP_ST_ST  = 4'd3,   // sum t * sum t, gives time variance
        OP_N_SWT  = 4'd4,   // n * sum w*t
        OP_SW_ST  = 4'd5,   // sum w * sum t, gives |covariance|
        OP_C_C    = 4'd6,   // covariance squared
        OP_L_L    = 4'd7,   // limit squared
        OP_VW_VT  = 4'd8,   // variance product
        OP_V_L    = 4'd9    // variance product * limit squared
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_ACCUM  = 3'd0,
        ST_ISSUE  = 3'd1,
        ST_WAIT   = 3'd2,
        ST_NEXT   = 3'd3,
        ST_DECIDE = 3'd4
    } state_t;

    // configuration registers
    typedef struct packed {
        logic [TIER_COUNT-1:0][W_LIM-1:0] limit;
        logic [TIER_COUNT-1:0][W_CNT-1:0] min_hits;
        logic [W_TIER-1:0]                tiers;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic acc_en;     // accumulate the accepted word
        logic start;      // start the multiplier for op
        logic store;      // store the multiplier result for op
        op_t  op;
        logic load_out;   // load the result word, clear the sums
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic degen;      // a variance is zero
    } status_t;

endpackage

`default_nettype wire

// File: src/lccf_mul.sv
// ----------------------------------------------------------------------------
// lccf_mul
// Shift-add multiplier, one multiplier bit per cycle, shared by all products.
// ----------------------------------------------------------------------------
`default_nettype none

module lccf_mul (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lccf_pkg::W_SQ-1:0]   a,
    input  wire logic [lccf_pkg::W_V-1:0]    b,
    input  wire logic [lccf_pkg::W_NB-1:0]   nbits,
    output logic      [lccf_pkg::W_P-1:0]    prod,
    output logic                             done
);
    import lccf_pkg::*;

    logic [W_NB-1:0] cnt_reg;
    logic            done_reg;
    logic [W_P-1:0]  acc_reg;
    logic [W_P-1:0]  a_reg;
    logic [W_V-1:0]  b_reg;

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= nbits;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - W_NB'(1);
                done_reg <= (cnt_reg == W_NB'(1));
            end
        end
    end

    // partial product accumulation, multiplicand shifts up each step
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= W_P'(a);
            b_reg   <= b;
        end else if (cnt_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: src/lccf_datapath.sv
// ----------------------------------------------------------------------------
// lccf_datapath
// Running sums, operand selection, product registers and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lccf_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lccf_pkg::cfg_t            cfg,
    input  wire lccf_pkg::cmd_t            cmd,
    output lccf_pkg::status_t              status,
    input  wire logic [lccf_pkg::W_HIT-1:0] hit_wire,
    input  wire logic [lccf_pkg::W_HIT-1:0] hit_time,
    output logic                           keep_cluster,
    output logic      [lccf_pkg::W_CNT-1:0] cluster_hits,
    output logic                           hit_overflow
);
    import lccf_pkg::*;

    // running sums
    logic [W_CNT-1:0] count_reg;
    logic [W_S1-1:0]  sw_reg, st_reg;
    logic [W_S2-1:0]  sww_reg, stt_reg, swt_reg;
    logic             ovf_reg;

    // end-of-cluster intermediates
    logic [W_V-1:0]   tmp_reg, vw_reg, vt_reg, c_reg;
    logic [W_SQ-1:0]  lhs_reg, v2_reg;
    logic [W_L2-1:0]  l2_reg;
    logic [W_P-1:0]   rhs_reg;

    // result word
    logic             keep_reg;
    logic [W_CNT-1:0] hits_reg;
    logic             ovf_out_reg;

    logic [2*W_HIT-1:0] ww, tt, wt;
    logic [W_SQ-1:0]    mul_a;
    logic [W_V-1:0]     mul_b;
    logic [W_NB-1:0]    mul_nbits;
    logic [W_P-1:0]     prod;
    logic               mul_done;
    logic [W_V-1:0]     prod_v;
    logic [W_LIM-1:0]   limit;
    logic [W_TIER-1:0]  used;
    logic               too_linear;

    assign ww = hit_wire * hit_wire;
    assign tt = hit_time * hit_time;
    assign wt = hit_wire * hit_time;

    // accumulation, capped at the hit limit
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            count_reg <= '0;
            sw_reg    <= '0;
            st_reg    <= '0;
            sww_reg   <= '0;
            stt_reg   <= '0;
            swt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.acc_en) begin
            if (count_reg < W_CNT'(MAX_HITS)) begin
                count_reg <= count_reg + W_CNT'(1);
                sw_reg    <= sw_reg + W_S1'(hit_wire);
                st_reg    <= st_reg + W_S1'(hit_time);
                sww_reg   <= sww_reg + W_S2'(ww);
                stt_reg   <= stt_reg + W_S2'(tt);
                swt_reg   <= swt_reg + W_S2'(wt);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // tier choice, last matching tier wins
    always_comb begin
        used  = (cfg.tiers == '0) ? W_TIER'(1) : cfg.tiers;
        limit = cfg.limit[0];
        for (int k = 0; k < TIER_COUNT; k++) begin
            if ((k < int'(used)) && (count_reg > cfg.min_hits[k])) begin
                limit = cfg.limit[k];
            end
        end
    end

    // operand selection per step
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_nbits = '0;
        case (cmd.op)
            OP_N_SWW: begin
                mul_a = W_SQ'(sww_reg); mul_b = W_V'(count_reg); mul_nbits = W_NB'(W_CNT);
            end
            OP_SW_SW: begin
                mul_a = W_SQ'(sw_reg); mul_b = W_V'(sw_reg); mul_nbits = W_NB'(W_S1);
            end
            OP_N_STT: begin
                mul_a = W_SQ'(stt_reg); mul_b = W_V'(count_reg); mul_nbits = W_NB'(W_CNT);
            end
            OP_ST_ST: begin
                mul_a = W_SQ'(st_reg); mul_b = W_V'(st_reg); mul_nbits = W_NB'(W_S1);
            end
            OP_N_SWT: begin
                mul_a = W_SQ'(swt_reg); mul_b = W_V'(count_reg); mul_nbits = W_NB'(W_CNT);
            end
            OP_SW_ST: begin
                mul_a = W_SQ'(sw_reg); mul_b = W_V'(st_reg); mul_nbits = W_NB'(W_S1);
            end
            OP_C_C: begin
                mul_a = W_SQ'(c_reg); mul_b = c_reg; mul_nbits = W_NB'(W_V);
            end
            OP_L_L: begin
                mul_a = W_SQ'(limit); mul_b = W_V'(limit); mul_nbits = W_NB'(W_LIM);
            end
            OP_VW_VT: begin
                mul_a = W_SQ'(vw_reg); mul_b = vt_reg; mul_nbits = W_NB'(W_V);
            end
            OP_V_L: begin
                mul_a = v2_reg; mul_b = W_V'(l2_reg); mul_nbits = W_NB'(W_L2);
            end
            default: begin
                mul_a = '0; mul_b = '0; mul_nbits = '0;
            end
        endcase
    end

    lccf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (mul_a),
        .b       (mul_b),
        .nbits   (mul_nbits),
        .prod    (prod),
        .done    (mul_done)
    );

    assign prod_v = prod[W_V-1:0];

    // product stores; variances cannot go negative
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            case (cmd.op)
                OP_N_SWW: tmp_reg <= prod_v;
                OP_SW_SW: vw_reg  <= tmp_reg - prod_v;
                OP_N_STT: tmp_reg <= prod_v;
                OP_ST_ST: vt_reg  <= tmp_reg - prod_v;
                OP_N_SWT: tmp_reg <= prod_v;
                OP_SW_ST: c_reg   <= (tmp_reg >= prod_v) ? tmp_reg - prod_v
                                                         : prod_v - tmp_reg;
                OP_C_C:   lhs_reg <= prod[W_SQ-1:0];
                OP_L_L:   l2_reg  <= prod[W_L2-1:0];
                OP_VW_VT: v2_reg  <= prod[W_SQ-1:0];
                OP_V_L:   rhs_reg <= prod;
                default:  tmp_reg <= tmp_reg;
            endcase
        end
    end

    // cov^2 * 2^32 against limit^2 * var_w * var_t
    assign too_linear = {(W_P - W_SQ - 32)'(0), lhs_reg, 32'd0} > rhs_reg;

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            keep_reg    <= status.degen || !too_linear;
            hits_reg    <= count_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign status.mul_done = mul_done;
    assign status.degen    = (vw_reg == '0) || (vt_reg == '0);
    assign keep_cluster    = keep_reg;
    assign cluster_hits    = hits_reg;
    assign hit_overflow    = ovf_out_reg;

endmodule

`default_nettype wire

// File: src/lccf_ctrl.sv
// ----------------------------------------------------------------------------
// lccf_ctrl
// Sequencer: accumulate hits, step through the products, hand out the word.
// ----------------------------------------------------------------------------
`default_nettype none

module lccf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tlast,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output lccf_pkg::cmd_t          cmd,
    input  wire lccf_pkg::status_t  status
);
    import lccf_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // state, step and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            op_reg      <= OP_N_SWW;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        case (state_reg)
            ST_ACCUM: begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    op_next    = OP_N_SWW;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.mul_done) begin
                    cmd.store  = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                // a flat cluster is kept without the remaining products
                if (op_reg == OP_V_L || (op_reg == OP_ST_ST && status.degen)) begin
                    state_next = ST_DECIDE;
                end else begin
                    op_next    = op_t'(op_reg + 4'd1);
                    state_next = ST_ISSUE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

    // a loaded result word is offered in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("result word not offered after load");

    // the multiplier runs at least one step after a start
    a_start_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !status.mul_done)
        else $error("multiplier done straight after start");

    // the last hit of a cluster starts the product sequence
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_ISSUE && op_reg == OP_N_SWW))
        else $error("last hit did not start the sequence");

    // no hit is accumulated in the wait and next-step states of the evaluation
    a_no_hit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT || state_reg == ST_NEXT) |-> !cmd.acc_en)
        else $error("hit accumulated during evaluation");

endmodule

`default_nettype wire

// File: src/linear_cluster_correlation_filter_top.sv
// ----------------------------------------------------------------------------
// linear_cluster_correlation_filter_top
// Keeps or removes a cluster by comparing |r| of wire against time to a tier limit.
// ----------------------------------------------------------------------------
// Throughput: one hit word per cycle while a cluster is being accumulated.
// Evaluation: after the last hit, 10 products run on one shift-add multiplier,
// one multiplier bit per cycle, with issue, wait and next-step states around
// each; the sequence ends after the two variances when one of them is zero.
// Hits are not taken during evaluation; a result word may wait at the output.
// Reset (aresetn, synchronous): sums cleared, registers to their defaults.
`default_nettype none

module linear_cluster_correlation_filter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // hit words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // hit_wire[12:0], hit_time[25:13], zero fill
    input  wire logic        s_tlast,   // hit_last
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // keep_cluster[0], cluster_hits[13:1],
                                        // hit_overflow[14], zero fill
    // register writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [lccf_pkg::W_ADDR-1:0]         cfg_addr,
    input  wire logic [lccf_pkg::W_LIM-1:0]          cfg_wr_data
);
    import lccf_pkg::*;

    cfg_t             cfg_reg;
    cmd_t             cmd;
    status_t          status;
    logic             keep_cluster;
    logic [W_CNT-1:0] cluster_hits;
    logic             hit_overflow;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TIER_COUNT; k++) begin
                cfg_reg.limit[k]    <= W_LIM'(65536);
                cfg_reg.min_hits[k] <= '0;
            end
            cfg_reg.tiers <= W_TIER'(1);
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_LIMIT_TIER0:    cfg_reg.limit[0]    <= cfg_wr_data;
                REG_LIMIT_TIER1:    cfg_reg.limit[1]    <= cfg_wr_data;
                REG_LIMIT_TIER2:    cfg_reg.limit[2]    <= cfg_wr_data;
                REG_MIN_HITS_TIER0: cfg_reg.min_hits[0] <= cfg_wr_data[W_CNT-1:0];
                REG_MIN_HITS_TIER1: cfg_reg.min_hits[1] <= cfg_wr_data[W_CNT-1:0];
                REG_MIN_HITS_TIER2: cfg_reg.min_hits[2] <= cfg_wr_data[W_CNT-1:0];
                REG_TIERS_IN_USE:   cfg_reg.tiers       <= cfg_wr_data[W_TIER-1:0];
                default:            cfg_reg             <= cfg_reg;
            endcase
        end
    end

    lccf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lccf_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .hit_wire     (s_tdata[W_HIT-1:0]),
        .hit_time     (s_tdata[2*W_HIT-1:W_HIT]),
        .keep_cluster (keep_cluster),
        .cluster_hits (cluster_hits),
        .hit_overflow (hit_overflow)
    );

    // pack the result word
    assign m_tdata = {1'b0, hit_overflow, cluster_hits, keep_cluster};

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear cluster correlation filter. Hit words are
// streamed in as clusters of various shapes and sizes, and a bit-exact model of
// the keep/remove decision, tier choice and hit-count saturation predicts each
// result word. Tier registers are rewritten between phases while the filter is
// idle, and both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb;

    import lccf_pkg::*;

    localparam int STALL_LIMIT   = 4000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 400;    // extra wait once every result word is in
    localparam int GAP_PCT       = 36;

    typedef struct packed {
        logic [W_HIT-1:0] hit_wire;
        logic [W_HIT-1:0] hit_time;
        logic             last;
    } hit_t;

    typedef struct packed {
        logic             keep;
        logic [W_CNT-1:0] hits;
        logic             ovf;
    } verdict_t;

    typedef enum int {
        SHAPE_LINE,
        SHAPE_SCATTER,
        SHAPE_FLAT_WIRE,
        SHAPE_FLAT_TIME
    } shape_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata     = '0;
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [15:0]       m_tdata;
    logic              cfg_wr_en   = 1'b0;
    logic [W_ADDR-1:0] cfg_addr    = '0;
    logic [W_LIM-1:0]  cfg_wr_data = '0;

    // shadow of the tier registers
    logic [W_LIM-1:0]  tier_limit [TIER_COUNT];
    logic [W_CNT-1:0]  tier_min_hits [TIER_COUNT];
    logic [W_TIER-1:0] tiers_used;

    // running sums of the cluster being received
    logic [63:0] acc_count, acc_sw, acc_st, acc_sww, acc_stt, acc_swt;
    logic        acc_ovf;

    verdict_t verdict_q [$];
    verdict_t want;

    bit sender_gaps = 1'b0;
    bit sink_gaps   = 1'b0;
    int error_count = 0;
    int hit_total   = 0;
    int cluster_total = 0;
    int kept_total  = 0;
    int removed_total = 0;
    int ovf_total   = 0;
    int idle_cycles = 0;

    linear_cluster_correlation_filter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // exact |r| > limit test: cov^2 * 2^32 against limit^2 * var_w * var_t
    function automatic logic keeps_cluster(input logic [63:0] n, input logic [W_LIM-1:0] lim);
        logic [255:0] nn, var_w, var_t, cov_a, cov_b, cov, lhs, rhs, ll;
        nn    = n;
        var_w = nn * acc_sww - acc_sw * acc_sw;
        var_t = nn * acc_stt - acc_st * acc_st;
        if (var_w == 0 || var_t == 0)
            return 1'b1;
        cov_a = nn * acc_swt;
        cov_b = acc_sw * acc_st;
        cov   = (cov_a >= cov_b) ? cov_a - cov_b : cov_b - cov_a;
        lhs   = (cov * cov) << 32;
        ll    = lim;
        rhs   = ll * ll * var_w * var_t;
        return !(lhs > rhs);
    endfunction

    // fold one accepted hit into the sums, queue the verdict on the last one
    task automatic absorb_hit(input hit_t h);
        verdict_t         v;
        int               used;
        logic [W_LIM-1:0] lim;
        logic [63:0]      w, t;
        w = h.hit_wire;
        t = h.hit_time;
        if (acc_count < MAX_HITS) begin
            acc_count = acc_count + 1;
            acc_sw    = acc_sw + w;
            acc_st    = acc_st + t;
            acc_sww   = acc_sww + w * w;
            acc_stt   = acc_stt + t * t;
            acc_swt   = acc_swt + w * t;
        end else begin
            acc_ovf = 1'b1;
        end
        if (!h.last)
            return;
        // tier count of zero acts as one; later tiers win
        used = (tiers_used == 0) ? 1 : int'(tiers_used);
        lim  = tier_limit[0];
        for (int k = 0; k < used; k++) begin
            if (acc_count > tier_min_hits[k])
                lim = tier_limit[k];
        end
        v.keep = keeps_cluster(acc_count, lim);
        v.hits = acc_count[W_CNT-1:0];
        v.ovf  = acc_ovf;
        verdict_q = {verdict_q, v};
        cluster_total++;
        acc_count = 0;
        acc_sw    = 0;
        acc_st    = 0;
        acc_sww   = 0;
        acc_stt   = 0;
        acc_swt   = 0;
        acc_ovf   = 1'b0;
    endtask

    task automatic send_hit(input hit_t h);
        @(negedge aclk);
        while (sender_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, h.hit_time, h.hit_wire};
        s_tlast  <= h.last;
        do @(posedge aclk); while (!s_tready);
        absorb_hit(h);
        hit_total++;
    endtask

    task automatic send_pair(input int w, input int t, input bit last);
        hit_t h;
        h.hit_wire = w[W_HIT-1:0];
        h.hit_time = t[W_HIT-1:0];
        h.last     = last;
        send_hit(h);
    endtask

    function automatic int clamp_hit(input int v);
        if (v < 0)
            return 0;
        if (v > 8191)
            return 8191;
        return v;
    endfunction

    // one cluster of the given shape; the last hit carries tlast
    task automatic send_cluster(input shape_t shape, input int len);
        int w0, t0, dw, dt, jit, w, t, pick;
        w0   = $urandom_range(0, 8191);
        t0   = $urandom_range(0, 8191);
        dw   = int'($urandom_range(0, 6)) - 3;
        dt   = int'($urandom_range(0, 80)) - 40;
        pick = $urandom_range(0, 3);
        jit  = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 5 : 50;
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_LINE: begin
                    w = w0 + k * dw + int'($urandom_range(0, 2 * jit)) - jit;
                    t = t0 + k * dt + int'($urandom_range(0, 2 * jit)) - jit;
                end
                SHAPE_SCATTER: begin
                    w = $urandom_range(0, 8191);
                    t = $urandom_range(0, 8191);
                end
                SHAPE_FLAT_WIRE: begin
                    w = w0;
                    t = $urandom_range(0, 8191);
                end
                default: begin
                    w = $urandom_range(0, 8191);
                    t = t0;
                end
            endcase
            send_pair(clamp_hit(w), clamp_hit(t), k == len - 1);
        end
    endtask

    // hold the sender, wait for every verdict, then let the filter settle
    task automatic drain(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [W_LIM-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            REG_LIMIT_TIER0:    tier_limit[0]    = val;
            REG_LIMIT_TIER1:    tier_limit[1]    = val;
            REG_LIMIT_TIER2:    tier_limit[2]    = val;
            REG_MIN_HITS_TIER0: tier_min_hits[0] = val[W_CNT-1:0];
            REG_MIN_HITS_TIER1: tier_min_hits[1] = val[W_CNT-1:0];
            REG_MIN_HITS_TIER2: tier_min_hits[2] = val[W_CNT-1:0];
            REG_TIERS_IN_USE:   tiers_used       = val[W_TIER-1:0];
            default: ;
        endcase
    endtask

    task automatic write_tiers(input int l0, input int l1, input int l2,
                               input int m0, input int m1, input int m2, input int used);
        write_reg(REG_LIMIT_TIER0, l0[W_LIM-1:0]);
        write_reg(REG_LIMIT_TIER1, l1[W_LIM-1:0]);
        write_reg(REG_LIMIT_TIER2, l2[W_LIM-1:0]);
        write_reg(REG_MIN_HITS_TIER0, {4'b0, m0[W_CNT-1:0]});
        write_reg(REG_MIN_HITS_TIER1, {4'b0, m1[W_CNT-1:0]});
        write_reg(REG_MIN_HITS_TIER2, {4'b0, m2[W_CNT-1:0]});
        write_reg(REG_TIERS_IN_USE, {15'b0, used[W_TIER-1:0]});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // registers untouched since reset: every limit is 1.0, so all kept
    task automatic test_reset_state();
        send_pair(0, 0, 1'b1);
        send_pair(0, 0, 1'b0);
        send_pair(4095, 4095, 1'b0);
        send_pair(8191, 8191, 1'b1);
        drain(SETTLE_CYCLES);
    endtask

    // zero limit, limit just under one, zero variance on either axis
    task automatic test_limit_extremes();
        write_tiers(0, 0, 0, 0, 0, 0, 3);
        send_pair(0, 8191, 1'b0);
        send_pair(8191, 0, 1'b1);
        send_pair(100, 5, 1'b0);
        send_pair(100, 9, 1'b0);
        send_pair(100, 7, 1'b1);
        send_pair(5, 8191, 1'b0);
        send_pair(9, 8191, 1'b1);
        drain(SETTLE_CYCLES);
        write_tiers(65535, 65535, 65535, 0, 0, 0, 1);
        send_pair(1, 1, 1'b0);
        send_pair(2, 2, 1'b1);
        drain(SETTLE_CYCLES);
    endtask

    // count thresholds pick the tier, the last one that applies wins
    task automatic test_tier_choice();
        write_tiers(0, 65536, 0, 0, 3, 4, 3);
        send_cluster(SHAPE_LINE, 3);
        send_cluster(SHAPE_LINE, 4);
        send_cluster(SHAPE_LINE, 5);
        drain(SETTLE_CYCLES);
        // tier count of zero falls back to tier zero alone
        write_tiers(65536, 0, 0, 0, 0, 0, 0);
        send_pair(10, 20, 1'b0);
        send_pair(30, 40, 1'b1);
        drain(SETTLE_CYCLES);
    endtask

    function automatic int pick_limit();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return 65536;
            2: return 131071;
            3: return 65535;
            4, 5: return $urandom_range(0, 65536);
            default: return $urandom_range(55000, 65535);
        endcase
    endfunction

    function automatic int pick_min_hits();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return 8191;
            2: return 4096;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // random clusters over several tier settings
    task automatic test_random_clusters();
        int start_hits, len, r;
        shape_t shape;
        bit paused;
        paused = 1'b0;
        for (int ph = 0; ph < 8; ph++) begin
            write_tiers(pick_limit(), pick_limit(), pick_limit(),
                        pick_min_hits(), pick_min_hits(), pick_min_hits(),
                        $urandom_range(0, 3));
            // first phase runs flat out on both sides
            sender_gaps = (ph != 0);
            sink_gaps   = (ph != 0);
            start_hits  = hit_total;
            while (hit_total - start_hits < 170) begin
                r = $urandom_range(0, 9);
                len = (r == 0) ? 1 : (r <= 6) ? $urandom_range(2, 10) :
                      (r <= 8) ? $urandom_range(11, 30) : $urandom_range(31, 80);
                r = $urandom_range(0, 9);
                shape = (r <= 5) ? SHAPE_LINE : (r <= 7) ? SHAPE_SCATTER :
                        (r == 8) ? SHAPE_FLAT_WIRE : SHAPE_FLAT_TIME;
                send_cluster(shape, len);
                // sender holds off once until the output has caught up
                if (ph == 4 && !paused && hit_total - start_hits > 80) begin
                    drain(0);
                    paused = 1'b1;
                end
            end
            drain(SETTLE_CYCLES);
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= !sink_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    // compare each result word with the oldest pending verdict
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result word %h with no cluster pending", $time, m_tdata);
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.keep) begin
                    $display("%0t: keep_cluster expected %0d got %0d",
                             $time, want.keep, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[13:1] !== want.hits) begin
                    $display("%0t: cluster_hits expected %0d got %0d",
                             $time, want.hits, m_tdata[13:1]);
                    error_count++;
                end
                if (m_tdata[14] !== want.ovf) begin
                    $display("%0t: hit_overflow expected %0d got %0d",
                             $time, want.ovf, m_tdata[14]);
                    error_count++;
                end
                if (want.keep)
                    kept_total++;
                else
                    removed_total++;
                if (want.ovf)
                    ovf_total++;
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("linear_cluster_correlation_filter_top verification failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < TIER_COUNT; k++) begin
            tier_limit[k]    = 17'd65536;
            tier_min_hits[k] = '0;
        end
        tiers_used = 2'd1;
        acc_count  = 0;
        acc_sw     = 0;
        acc_st     = 0;
        acc_sww    = 0;
        acc_stt    = 0;
        acc_swt    = 0;
        acc_ovf    = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_limit_extremes();
        test_tier_choice();
        test_random_clusters();

        drain(SETTLE_CYCLES);
        $display("covered %0d clusters from %0d hits: %0d kept, %0d removed",
                 cluster_total, hit_total, kept_total, removed_total);
        $display("%0d clusters past the hit limit, tier settings incl. zero and full limits",
                 ovf_total);
        if (error_count == 0) begin
            $display("linear_cluster_correlation_filter_top verification clean");
        end else begin
            $display("linear_cluster_correlation_filter_top verification failed");
        end
        $finish;
    end

endmodule
